// ===== src/mra_pkg.sv =====
// Package with the shared types and constants of the multi-resource admission unit.
`default_nettype none
package mra_pkg;

  localparam int ALL_TYPES = 7;
  localparam int NEED_W    = 4;
  localparam int LIMIT_W   = 8;
  localparam int FIELD_W   = 8;
  localparam int OPCODE_W  = 2;
  localparam int CFG_IDX_W = 3;
  localparam int Q_DEPTH   = 4;
  localparam int Q_PTR_W   = 2;
  localparam int Q_CNT_W   = 3;

  typedef enum logic [OPCODE_W-1:0] {
    OP_ADMIT   = 2'd0,
    OP_RELEASE = 2'd1,
    OP_CHECK   = 2'd2,
    OP_FORCE   = 2'd3
  } op_t;

  typedef logic [ALL_TYPES-1:0][NEED_W-1:0] need_vec_t;
  typedef logic [ALL_TYPES-1:0][FIELD_W-1:0] used_vec_t;

  typedef struct packed {
    logic      do_admit;
    logic      do_release;
    logic      do_check;
    logic      do_force;
    need_vec_t need;
  } req_t;

endpackage
`default_nettype wire

// ===== src/mra_front.sv =====
// Front stage: accepts requests, decodes the opcode and masks unused types.
`default_nettype none
module mra_front #(
  parameter int NUM_TYPES = 7
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [mra_pkg::OPCODE_W-1:0]      in_opcode,
  input  wire mra_pkg::need_vec_t                in_need,
  output logic                                   req_valid,
  input  wire logic                              req_ready,
  output mra_pkg::req_t                          req
);

  logic          valid_r;
  logic          valid_nxt;
  mra_pkg::req_t req_r;
  mra_pkg::req_t req_nxt;
  mra_pkg::op_t  op;

  assign in_ready  = !valid_r || req_ready;
  assign req_valid = valid_r;
  assign req       = req_r;

  always_comb begin
    op = mra_pkg::op_t'(in_opcode);
    req_nxt.do_admit   = 1'b0;
    req_nxt.do_release = 1'b0;
    req_nxt.do_check   = 1'b0;
    req_nxt.do_force   = 1'b0;
    case (op)
      mra_pkg::OP_ADMIT:   req_nxt.do_admit   = 1'b1;
      mra_pkg::OP_RELEASE: req_nxt.do_release = 1'b1;
      mra_pkg::OP_CHECK:   req_nxt.do_check   = 1'b1;
      mra_pkg::OP_FORCE:   req_nxt.do_force   = 1'b1;
      default:             req_nxt.do_check   = 1'b1;
    endcase
    for (int t = 0; t < mra_pkg::ALL_TYPES; t++) begin
      req_nxt.need[t] = (t < NUM_TYPES) ? in_need[t] : '0;
    end
    valid_nxt = valid_r;
    if (in_ready) begin
      valid_nxt = in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req_r <= req_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== src/mra_queue.sv =====
// Short request queue that decouples the front stage from the counter stage.
`default_nettype none
module mra_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push_valid,
  output logic               push_ready,
  input  wire mra_pkg::req_t push_data,
  output logic               pop_valid,
  input  wire logic          pop_ready,
  output mra_pkg::req_t      pop_data
);

  mra_pkg::req_t                 mem [mra_pkg::Q_DEPTH];
  logic [mra_pkg::Q_PTR_W-1:0]   wptr_r;
  logic [mra_pkg::Q_PTR_W-1:0]   wptr_nxt;
  logic [mra_pkg::Q_PTR_W-1:0]   rptr_r;
  logic [mra_pkg::Q_PTR_W-1:0]   rptr_nxt;
  logic [mra_pkg::Q_CNT_W-1:0]   count_r;
  logic [mra_pkg::Q_CNT_W-1:0]   count_nxt;
  logic                          push;
  logic                          pop;

  assign push_ready = (count_r != mra_pkg::Q_CNT_W'(mra_pkg::Q_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = mem[rptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_comb begin
    wptr_nxt  = push ? wptr_r + 1'b1 : wptr_r;
    rptr_nxt  = pop ? rptr_r + 1'b1 : rptr_r;
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr_r] <= push_data;
    end
  end

endmodule
`default_nettype wire

// ===== src/mra_back.sv =====
// Counter stage: holds limits and running counts, executes requests and registers results.
`default_nettype none
module mra_back #(
  parameter int NUM_TYPES  = 7,
  parameter int COUNT_BITS = 8
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_we,
  input  wire logic [mra_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [mra_pkg::LIMIT_W-1:0]     cfg_wdata,
  input  wire logic                            req_valid,
  output logic                                 req_ready,
  input  wire mra_pkg::req_t                   req,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic                                 out_granted,
  output mra_pkg::used_vec_t                   out_used
);

  localparam int SUM_W = ((COUNT_BITS > mra_pkg::FIELD_W) ? COUNT_BITS : mra_pkg::FIELD_W) + 1;
  localparam logic [SUM_W-1:0] COUNT_MAX = SUM_W'({COUNT_BITS{1'b1}});

  logic [COUNT_BITS-1:0]        cnt_r     [NUM_TYPES];
  logic [COUNT_BITS-1:0]        cnt_nxt   [NUM_TYPES];
  logic [mra_pkg::LIMIT_W-1:0]  limit_r   [NUM_TYPES];
  logic                         out_valid_r;
  logic                         out_granted_r;
  logic                         granted_nxt;
  mra_pkg::used_vec_t           out_used_r;
  mra_pkg::used_vec_t           used_nxt;
  logic                         pop;
  logic                         admit_ok;
  logic                         check_ok;
  logic [SUM_W-1:0]             sum;
  logic [SUM_W-1:0]             used_ext;
  logic [SUM_W-1:0]             need_ext;
  logic [SUM_W-1:0]             lim_ext;
  logic [SUM_W-1:0]             sat_add [NUM_TYPES];
  logic [SUM_W-1:0]             sub     [NUM_TYPES];

  assign req_ready   = !out_valid_r || out_ready;
  assign pop         = req_valid && req_ready;
  assign out_valid   = out_valid_r;
  assign out_granted = out_granted_r;
  assign out_used    = out_used_r;

  always_comb begin
    admit_ok = 1'b1;
    check_ok = 1'b1;
    sum      = '0;
    used_ext = '0;
    need_ext = '0;
    lim_ext  = '0;
    used_nxt = '0;
    for (int t = 0; t < NUM_TYPES; t++) begin
      used_ext = SUM_W'(cnt_r[t]);
      need_ext = SUM_W'(req.need[t]);
      lim_ext  = SUM_W'(limit_r[t]);
      sum      = used_ext + need_ext;
      if (sum > lim_ext) begin
        admit_ok = 1'b0;
      end
      if (need_ext > lim_ext) begin
        check_ok = 1'b0;
      end
      sat_add[t] = (sum > COUNT_MAX) ? COUNT_MAX : sum;
      sub[t]     = (used_ext > need_ext) ? used_ext - need_ext : '0;
    end
    for (int t = 0; t < NUM_TYPES; t++) begin
      cnt_nxt[t] = cnt_r[t];
      if ((req.do_admit && admit_ok) || req.do_force) begin
        cnt_nxt[t] = sat_add[t][COUNT_BITS-1:0];
      end else if (req.do_release) begin
        cnt_nxt[t] = sub[t][COUNT_BITS-1:0];
      end
      used_nxt[t] = mra_pkg::FIELD_W'(SUM_W'(cnt_nxt[t]));
    end
    granted_nxt = 1'b1;
    if (req.do_admit) begin
      granted_nxt = admit_ok;
    end else if (req.do_check) begin
      granted_nxt = check_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      for (int t = 0; t < NUM_TYPES; t++) begin
        cnt_r[t]   <= '0;
        limit_r[t] <= '0;
      end
    end else begin
      if (req_ready) begin
        out_valid_r <= req_valid;
      end
      for (int t = 0; t < NUM_TYPES; t++) begin
        if (pop) begin
          cnt_r[t] <= cnt_nxt[t];
        end
        if (cfg_we && (cfg_index == mra_pkg::CFG_IDX_W'(t))) begin
          limit_r[t] <= cfg_wdata;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_granted_r <= granted_nxt;
      out_used_r    <= used_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== src/multi_resource_admission_unit.sv =====
// Top level of the multi-resource admission unit.
//
// Channel   Direction  Handshake            Payload
// in_       input      in_valid/in_ready    in_opcode, in_need_* (4 bits each)
// out_      output     out_valid/out_ready  out_granted, out_used_* (8 bits each)
// cfg_      input      cfg_we               cfg_index (3 bits), cfg_wdata (8 bits)
//
// One request per cycle is sustained while out_ready is high; a request passes the front register,
// the queue and the output register in turn before its result is valid.
// The counter update in the counter stage sets the rate: all types update together.
// Synchronous reset clears counters and limits to zero at once.
// When out_ready is low, the output register, the four-entry queue and the front
// register fill in turn before in_ready drops.
`default_nettype none
module multi_resource_admission_unit #(
  parameter int NUM_TYPES  = 7,
  parameter int COUNT_BITS = 8
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_we,
  input  wire logic [mra_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [mra_pkg::LIMIT_W-1:0]     cfg_wdata,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [mra_pkg::OPCODE_W-1:0]    in_opcode,
  input  wire logic [mra_pkg::NEED_W-1:0]      in_need_nop,
  input  wire logic [mra_pkg::NEED_W-1:0]      in_need_bcompress,
  input  wire logic [mra_pkg::NEED_W-1:0]      in_need_bdecompress,
  input  wire logic [mra_pkg::NEED_W-1:0]      in_need_gcompress,
  input  wire logic [mra_pkg::NEED_W-1:0]      in_need_gdecompress,
  input  wire logic [mra_pkg::NEED_W-1:0]      in_need_encrypt,
  input  wire logic [mra_pkg::NEED_W-1:0]      in_need_decrypt,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic                                 out_granted,
  output logic [mra_pkg::FIELD_W-1:0]          out_used_nop,
  output logic [mra_pkg::FIELD_W-1:0]          out_used_bcompress,
  output logic [mra_pkg::FIELD_W-1:0]          out_used_bdecompress,
  output logic [mra_pkg::FIELD_W-1:0]          out_used_gcompress,
  output logic [mra_pkg::FIELD_W-1:0]          out_used_gdecompress,
  output logic [mra_pkg::FIELD_W-1:0]          out_used_encrypt,
  output logic [mra_pkg::FIELD_W-1:0]          out_used_decrypt
);

  mra_pkg::need_vec_t in_need;
  mra_pkg::used_vec_t out_used;
  mra_pkg::req_t      f_req;
  mra_pkg::req_t      q_req;
  logic               f_valid;
  logic               f_ready;
  logic               q_valid;
  logic               q_ready;

  assign in_need[0] = in_need_nop;
  assign in_need[1] = in_need_bcompress;
  assign in_need[2] = in_need_bdecompress;
  assign in_need[3] = in_need_gcompress;
  assign in_need[4] = in_need_gdecompress;
  assign in_need[5] = in_need_encrypt;
  assign in_need[6] = in_need_decrypt;

  assign out_used_nop         = out_used[0];
  assign out_used_bcompress   = out_used[1];
  assign out_used_bdecompress = out_used[2];
  assign out_used_gcompress   = out_used[3];
  assign out_used_gdecompress = out_used[4];
  assign out_used_encrypt     = out_used[5];
  assign out_used_decrypt     = out_used[6];

  mra_front #(
    .NUM_TYPES (NUM_TYPES)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_opcode (in_opcode),
    .in_need   (in_need),
    .req_valid (f_valid),
    .req_ready (f_ready),
    .req       (f_req)
  );

  mra_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_data  (f_req),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_data   (q_req)
  );

  mra_back #(
    .NUM_TYPES  (NUM_TYPES),
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .req_valid   (q_valid),
    .req_ready   (q_ready),
    .req         (q_req),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_granted (out_granted),
    .out_used    (out_used)
  );

endmodule
`default_nettype wire
